FILE: rtl/core/vsd_pkg.sv
// Shared constants and codes for the variable-length integer stream decoder.
// No dependencies; imported by varint_stream_decoder.
`timescale 1ns / 1ps

package vsd_pkg;

	// Default width of the decoded value (legal range 8 to 64).
	localparam int VALUE_BITS_DEF = 64;

	// Output payload layout.
	localparam int OUT_VALUE_W  = 64;
	localparam int OUT_COUNT_W  = 4;
	localparam int OUT_STATUS_W = 2;
	localparam int OUT_FIELDS_W = OUT_VALUE_W + OUT_COUNT_W;
	localparam int M_TDATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;
	localparam int M_PAD_W      = M_TDATA_W - OUT_FIELDS_W;

	// Input byte layout.
	localparam int IN_BYTE_W  = 8;
	localparam int CONT_BIT   = 7;
	localparam int LOW7_W     = 7;
	localparam int LOW6_W     = 6;
	localparam int SIGN_BIT   = 0;

	localparam logic [OUT_COUNT_W-1:0] COUNT_MAX = 4'd15;

	// Status codes.
	localparam logic [OUT_STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [OUT_STATUS_W-1:0] STATUS_TRUNC = 2'd1;
	localparam logic [OUT_STATUS_W-1:0] STATUS_OVF   = 2'd2;

	// Value kinds carried on the input tuser.
	localparam logic KIND_UNSIGNED = 1'b0;
	localparam logic KIND_SIGNED   = 1'b1;

endpackage

FILE: rtl/core/varint_stream_decoder.sv
// Big-endian variable-length integer decoder, one encoded byte per item.
// Depends on vsd_pkg for layout constants and status/kind codes.
//
//  channel   dir  tdata                              tuser        tlast
//  s_axis    in   [7:0] data_byte                    kind         end_of_buffer
//  m_axis    out  [63:0] value, [67:64] byte_count   [1:0] status -
//
// Takes one byte per cycle unless the result side stalls; a result is offered
// once its final byte has passed the input register, then the result register.
// The decode between the two registers is a 7-bit or 6-bit shift, an OR-reduce
// of the bits shifted out and one negate of the VALUE_BITS accumulator.
// arst_n clears the valid flags and the decoder state (accumulator, overflow
// flag, byte counter). A stalled result holds in the result register while
// the input register can still take one more byte.
`timescale 1ns / 1ps

module varint_stream_decoder
	import vsd_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [IN_BYTE_W-1:0] s_axis_tdata,   // [7:0] data_byte
	input  logic                 s_axis_tuser,   // [0] kind
	input  logic                 s_axis_tlast,   // end_of_buffer

	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [M_TDATA_W-1:0] m_axis_tdata,   // [63:0] value, [67:64] byte_count, pad
	output logic [OUT_STATUS_W-1:0] m_axis_tuser // [1:0] status
);

	// Input register
	logic                 in_valid_s1;
	logic [IN_BYTE_W-1:0] in_byte_s1;
	logic                 in_kind_s1;
	logic                 in_eob_s1;

	// Decoder state
	logic [VALUE_BITS-1:0]  acc_q;
	logic                   ovf_q;
	logic [OUT_COUNT_W-1:0] cnt_q;

	// Result register
	logic                    out_valid_s2;
	logic [OUT_VALUE_W-1:0]  out_value_s2;
	logic [OUT_COUNT_W-1:0]  out_count_s2;
	logic [OUT_STATUS_W-1:0] out_status_s2;

	logic out_free;
	logic s1_fire;
	logic is_cont;
	logic emit;
	logic is_signed_final;
	logic [VALUE_BITS-1:0]   sh7;
	logic [VALUE_BITS-1:0]   sh6;
	logic [VALUE_BITS-1:0]   res_w;
	logic                    lost7;
	logic                    lost6;
	logic                    ovf_n;
	logic [OUT_COUNT_W-1:0]  cnt_n;
	logic [OUT_VALUE_W-1:0]  value_n;
	logic [OUT_STATUS_W-1:0] status_n;

	assign out_free      = !out_valid_s2 || m_axis_tready;
	assign s1_fire       = in_valid_s1 && out_free;
	assign s_axis_tready = !in_valid_s1 || out_free;

	always_comb begin
		is_cont         = in_byte_s1[CONT_BIT];
		emit            = !is_cont || in_eob_s1;
		is_signed_final = !is_cont && (in_kind_s1 == KIND_SIGNED);

		sh7   = {acc_q[VALUE_BITS-LOW7_W-1:0], in_byte_s1[LOW7_W-1:0]};
		sh6   = {acc_q[VALUE_BITS-LOW6_W-1:0], in_byte_s1[LOW6_W:1]};
		lost7 = |acc_q[VALUE_BITS-1 -: LOW7_W];
		lost6 = |acc_q[VALUE_BITS-1 -: LOW6_W];

		ovf_n = ovf_q | (is_signed_final ? lost6 : lost7);
		cnt_n = (cnt_q == COUNT_MAX) ? COUNT_MAX : cnt_q + 1'b1;

		// negate the magnitude when the sign bit is set
		res_w = (in_byte_s1[SIGN_BIT]) ? ({VALUE_BITS{1'b0}} - sh6) : sh6;

		if (is_cont) begin
			value_n  = '0;
			status_n = STATUS_TRUNC;
		end else begin
			if (is_signed_final) begin
				value_n = OUT_VALUE_W'($signed(res_w));
			end else begin
				value_n = OUT_VALUE_W'(sh7);
			end
			status_n = ovf_n ? STATUS_OVF : STATUS_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			in_byte_s1 <= s_axis_tdata;
			in_kind_s1 <= s_axis_tuser;
			in_eob_s1  <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			ovf_q <= 1'b0;
			cnt_q <= '0;
		end else if (s1_fire) begin
			if (emit) begin
				acc_q <= '0;
				ovf_q <= 1'b0;
				cnt_q <= '0;
			end else begin
				acc_q <= sh7;
				ovf_q <= ovf_n;
				cnt_q <= cnt_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (out_free) begin
			out_valid_s2 <= in_valid_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && emit) begin
			out_value_s2  <= value_n;
			out_count_s2  <= cnt_n;
			out_status_s2 <= status_n;
		end
	end

	assign m_axis_tvalid = out_valid_s2;
	assign m_axis_tdata  = {{M_PAD_W{1'b0}}, out_count_s2, out_value_s2};
	assign m_axis_tuser  = out_status_s2;

`ifndef ASSERT_OFF
	// A truncated value always reads as zero.
	a_trunc_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == STATUS_TRUNC) |-> (out_value_s2 == '0))
		else $error("truncated result carries nonzero value");

	// Every result used at least one byte.
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (out_count_s2 != '0))
		else $error("result with zero byte count");

	// Status is one of the three defined codes.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser == STATUS_OK || m_axis_tuser == STATUS_TRUNC ||
			m_axis_tuser == STATUS_OVF))
		else $error("undefined status code");

	// Decoder state is cleared after a value closes.
	a_state_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && emit) |=> (acc_q == '0 && !ovf_q && cnt_q == '0))
		else $error("decoder state not cleared after result");

	// A closing byte in the input register lands in the result register.
	a_emit_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && emit) |=> out_valid_s2)
		else $error("closing item did not produce a result");

	// Input stalls only when the input register holds an item.
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (in_valid_s1 && out_valid_s2))
		else $error("input stalled without a held item");
`endif

endmodule

FILE: sim/vsd_checker.sv
// Scoreboard for varint_stream_decoder: watches both stream channels, decodes
// every accepted byte on its own and compares each result it sees.
// Depends on vsd_pkg for widths, status codes and kind codes.
`timescale 1ns / 1ps

module vsd_checker
	import vsd_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_axis_tvalid,
	input  logic                    s_axis_tready,
	input  logic [IN_BYTE_W-1:0]    s_axis_tdata,
	input  logic                    s_axis_tuser,
	input  logic                    s_axis_tlast,
	input  logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	input  logic [M_TDATA_W-1:0]    m_axis_tdata,
	input  logic [OUT_STATUS_W-1:0] m_axis_tuser,
	output int                      errors,
	output int                      pending,
	output int                      checked
);

	localparam int VW = VALUE_BITS_DEF;
	localparam logic [63:0] VMASK = {64{1'b1}} >> (64 - VW);
	localparam int PRINT_CAP = 100;

	typedef struct packed {
		logic [OUT_VALUE_W-1:0]  value;
		logic [OUT_COUNT_W-1:0]  count;
		logic [OUT_STATUS_W-1:0] status;
	} decoded_t;

	decoded_t decoded_q[$];
	decoded_t want;

	// Decoder state as the block should hold it.
	logic [63:0]            acc;
	logic                   ovf;
	logic [OUT_COUNT_W-1:0] taken;

	initial begin
		errors = 0;
		pending = 0;
		checked = 0;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] exp_val);
		if (errors < PRINT_CAP)
			$display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, exp_val);
		errors++;
	endtask

	function automatic void clear_decode();
		acc = '0;
		ovf = 1'b0;
		taken = '0;
	endfunction

	// Append one predicted result at the tail of the queue.
	function automatic void add_expected(input decoded_t r);
		decoded_q.insert(decoded_q.size(), r);
	endfunction

	// Shift new bits in, flag any set bit pushed past the value width.
	function automatic void shift_bits(input int sh, input logic [63:0] bits);
		if ((acc >> (VW - sh)) != 0)
			ovf = 1'b1;
		acc = ((acc << sh) | bits) & VMASK;
	endfunction

	function automatic void decode_byte(input logic [IN_BYTE_W-1:0] b, input logic kind,
			input logic eob);
		decoded_t r;
		logic [63:0] v;
		if (taken != COUNT_MAX)
			taken++;
		if (b[CONT_BIT]) begin
			shift_bits(LOW7_W, 64'(b[LOW7_W-1:0]));
			// Buffer ran out mid value: truncation wins over overflow.
			if (eob) begin
				r.value = '0;
				r.count = taken;
				r.status = STATUS_TRUNC;
				add_expected(r);
				clear_decode();
			end
		end else begin
			if (kind == KIND_SIGNED) begin
				shift_bits(LOW6_W, 64'(b[LOW6_W:1]));
				v = acc;
				if (b[SIGN_BIT])
					v = (64'd0 - v) & VMASK;
				if (VW < 64 && v[VW-1])
					v = v | ~VMASK;
			end else begin
				shift_bits(LOW7_W, 64'(b[LOW7_W-1:0]));
				v = acc;
			end
			r.value = v;
			r.count = taken;
			r.status = ovf ? STATUS_OVF : STATUS_OK;
			add_expected(r);
			clear_decode();
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_decode();
			decoded_q.delete();
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (decoded_q.size() == 0) begin
					report_mismatch("result with nothing expected",
						64'(m_axis_tdata[OUT_VALUE_W-1:0]), 64'd0);
				end else begin
					want = decoded_q.pop_front();
					checked++;
					if (m_axis_tdata[OUT_VALUE_W-1:0] !== want.value)
						report_mismatch("value", m_axis_tdata[OUT_VALUE_W-1:0], want.value);
					if (m_axis_tdata[OUT_FIELDS_W-1:OUT_VALUE_W] !== want.count)
						report_mismatch("byte_count",
							64'(m_axis_tdata[OUT_FIELDS_W-1:OUT_VALUE_W]), 64'(want.count));
					if (m_axis_tuser !== want.status)
						report_mismatch("status", 64'(m_axis_tuser), 64'(want.status));
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				decode_byte(s_axis_tdata, s_axis_tuser, s_axis_tlast);
		end
		pending = decoded_q.size();
	end

endmodule

FILE: sim/tb_top.sv
// Top of the varint_stream_decoder testbench: clock, reset, byte stimulus,
// result-side pacing, watchdog and verdict. Depends on vsd_pkg,
// varint_stream_decoder and vsd_checker.
`timescale 1ns / 1ps

module tb_top
	import vsd_pkg::*;
();

	localparam int TARGET_BYTES = 1350;
	localparam int IDLE_LIMIT   = 5000;
	localparam int HOLD_CYCLES  = 150;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    s_axis_tvalid = 1'b0;
	logic                    s_axis_tready;
	logic [IN_BYTE_W-1:0]    s_axis_tdata = '0;
	logic                    s_axis_tuser = KIND_UNSIGNED;
	logic                    s_axis_tlast = 1'b0;
	logic                    m_axis_tvalid;
	logic                    m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0]    m_axis_tdata;
	logic [OUT_STATUS_W-1:0] m_axis_tuser;

	int errors, pending, checked;
	int burst_left = 0;
	int bytes_sent = 0;
	int n_values = 0, n_cut = 0, n_long = 0, n_noise = 0;
	int idle_cycles = 0;
	bit hold_req = 1'b0;

	always #10 clk = ~clk;

	varint_stream_decoder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	vsd_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.errors        (errors),
		.pending       (pending),
		.checked       (checked)
	);

	// Offer one byte, in bursts separated by random gaps; return after the
	// rising edge that accepts it.
	task automatic send_byte(input logic [7:0] b, input logic kind, input logic eob);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tuser <= kind;
		s_axis_tlast <= eob;
		do @(negedge clk); while (!s_axis_tready);
		@(posedge clk);
		burst_left--;
		bytes_sent++;
	endtask

	// Send len bytes of one value; with cut set all are continuation bytes
	// and the buffer ends on the last one.
	task automatic send_sequence(input int len, input bit cut);
		logic [6:0] payload;
		for (int i = 0; i < len; i++) begin
			payload = 7'($urandom);
			if (i == 0 && $urandom_range(0, 3) == 0)
				payload = 7'($urandom_range(0, 3));
			if (i < len - 1 || cut)
				send_byte({1'b1, payload}, 1'($urandom), cut && i == len - 1);
			else
				send_byte({1'b0, payload}, 1'($urandom), $urandom_range(0, 3) == 0);
		end
	endtask

	// Result side: random ready pattern, plus one long hold-off on request.
	initial begin : rx_pace
		int mode, run;
		bit hold_taken;
		hold_taken = 1'b0;
		@(posedge clk);
		forever begin
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			mode = $urandom_range(0, 3);
			run = $urandom_range(10, 60);
			repeat (run) begin
				case (mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= 1'($urandom);
					2: m_axis_tready <= ($urandom_range(0, 7) != 0);
					default: m_axis_tready <= ($urandom_range(0, 3) == 0);
				endcase
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no traffic for %0d cycles", IDLE_LIMIT);
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin : stimulus
		int pick, len;
		bit paused;
		paused = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: single-byte extremes, negative zero, a two-byte value,
		// a cut buffer, then a long overflowing signed value whose count
		// saturates.
		send_byte(8'h00, KIND_UNSIGNED, 1'b0);
		send_byte(8'h7F, KIND_UNSIGNED, 1'b1);
		send_byte(8'h01, KIND_SIGNED, 1'b0);
		send_byte(8'h7F, KIND_SIGNED, 1'b1);
		send_byte(8'h7E, KIND_SIGNED, 1'b0);
		send_byte(8'h81, KIND_UNSIGNED, 1'b0);
		send_byte(8'h00, KIND_UNSIGNED, 1'b0);
		send_byte(8'h85, KIND_UNSIGNED, 1'b1);
		for (int i = 0; i < 15; i++)
			send_byte(8'hFF, i[0] ? KIND_SIGNED : KIND_UNSIGNED, 1'b0);
		send_byte(8'h7F, KIND_SIGNED, 1'b0);

		while (bytes_sent < TARGET_BYTES) begin
			if (bytes_sent >= 400)
				hold_req = 1'b1;
			if (bytes_sent >= 900 && !paused) begin
				// Hold off the input until every result has drained.
				paused = 1'b1;
				s_axis_tvalid <= 1'b0;
				do @(negedge clk); while (pending != 0);
				@(posedge clk);
				burst_left = 0;
			end
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20)
					: $urandom_range(1, 9);
				if (len > 9)
					n_long++;
				n_values++;
				send_sequence(len, 1'b0);
			end else if (pick < 82) begin
				n_cut++;
				send_sequence($urandom_range(1, 12), 1'b1);
			end else begin
				len = $urandom_range(1, 4);
				n_noise += len;
				repeat (len)
					send_byte(8'($urandom), 1'($urandom), $urandom_range(0, 3) == 0);
			end
		end

		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
		$display("sent %0d bytes: %0d random values (%0d over nine bytes), %0d cut buffers,",
			bytes_sent, n_values, n_long, n_cut);
		$display("%0d stray bytes, one long output hold-off; %0d results compared",
			n_noise, checked);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/vsd_pkg.sv
rtl/core/varint_stream_decoder.sv
sim/vsd_checker.sv
sim/tb_top.sv
